/* hdl/nosd_pkg.sv */
`default_nettype none

package nosd_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH = 48;
    localparam int OUT_WIDTH    = 56;
    localparam int ORDER_WIDTH  = 4;
    localparam int COEF_WIDTH   = 16;
    localparam int COEF_MAX_N   = 16;

    localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(1);

    // input request payload
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           sample_null;
    } in_t;

    // result payload
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] diff_value;
        logic                        diff_valid;
    } out_t;

    // control carried along with the product stage
    typedef struct packed {
        logic vld;
        logic compute;
    } stage_ctrl_t;

    // signed tap weight (-1)^k * C(m,k), zero beyond the order (elaboration only)
    function automatic int tap_coef(input int m, input int k);
        int row [COEF_MAX_N+1];
        int c;
        for (int j = 0; j <= COEF_MAX_N; j++)
            row[j] = (j == 0) ? 1 : 0;
        // pascal rows built by addition
        for (int r = 1; r <= COEF_MAX_N; r++)
            if (r <= m)
                for (int j = COEF_MAX_N; j >= 1; j--)
                    row[j] = row[j] + row[j-1];
        c = (k <= m && k >= 0 && k <= COEF_MAX_N) ? row[k] : 0;
        return (k % 2 == 1) ? -c : c;
    endfunction

endpackage

`default_nettype wire

/* hdl/nosd_hist.sv */
`default_nettype none

module nosd_hist #(
    parameter int MAX_ORDER = 8,
    parameter int WW        = $clog2(MAX_ORDER + 1)
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            cfg_we,
    input  wire logic [nosd_pkg::ORDER_WIDTH-1:0]                cfg_wdata,
    input  wire logic                                            accept,
    input  wire nosd_pkg::in_t                                   sample,
    output logic      [MAX_ORDER-1:0][nosd_pkg::SAMPLE_WIDTH-1:0] hist,
    output logic      [WW-1:0]                                   eff_order,
    output logic                                                 compute
);

    logic [MAX_ORDER-1:0][nosd_pkg::SAMPLE_WIDTH-1:0] hist_reg, hist_next;
    logic [WW-1:0]                    warm_reg, warm_next;
    logic [nosd_pkg::ORDER_WIDTH-1:0] order_reg;
    logic [4:0]                       ord_ext;
    logic                             warming;

    // clamp the order into one through the maximum
    always_comb
    begin
        ord_ext = {1'b0, order_reg};
        if (ord_ext == 5'd0)
            eff_order = WW'(1);
        else if (ord_ext > 5'(MAX_ORDER))
            eff_order = WW'(MAX_ORDER);
        else
            eff_order = WW'(ord_ext);
    end

    assign warming = (warm_reg < eff_order);
    assign compute = !sample.sample_null && !warming;
    assign hist    = hist_reg;

    // newest sample enters at place zero
    genvar i;
    generate
        for (i = 0; i < MAX_ORDER; i++)
        begin : g_shift
            if (i == 0)
            begin : g_head
                assign hist_next[i] = sample.sample_value;
            end
            else
            begin : g_tail
                assign hist_next[i] = hist_reg[i-1];
            end
        end
    endgenerate

    // warm-up count saturates at the order
    assign warm_next = warming ? warm_reg + WW'(1) : warm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            warm_reg  <= '0;
            order_reg <= nosd_pkg::ORDER_RESET;
        end
        else
        begin
            if (cfg_we)
                order_reg <= cfg_wdata;
            if (accept && !sample.sample_null)
            begin
                hist_reg <= hist_next;
                warm_reg <= warm_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/nosd_prod.sv */
`default_nettype none

module nosd_prod #(
    parameter int MAX_ORDER = 8,
    parameter int WW        = $clog2(MAX_ORDER + 1)
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              advance,
    input  wire logic                                              accept,
    input  wire nosd_pkg::in_t                                     sample,
    input  wire logic      [MAX_ORDER-1:0][nosd_pkg::SAMPLE_WIDTH-1:0] hist,
    input  wire logic      [WW-1:0]                                eff_order,
    input  wire logic                                              compute,
    output nosd_pkg::stage_ctrl_t                                  ctrl,
    output logic           [MAX_ORDER:0][nosd_pkg::OUT_WIDTH-1:0]  prod
);

    localparam int FULL_WIDTH = nosd_pkg::SAMPLE_WIDTH + nosd_pkg::COEF_WIDTH;

    logic [nosd_pkg::COEF_WIDTH-1:0] coef_tab [MAX_ORDER][MAX_ORDER+1];
    logic [MAX_ORDER:0][nosd_pkg::OUT_WIDTH-1:0] prod_reg, prod_next;
    nosd_pkg::stage_ctrl_t ctrl_reg;

    // newest sample always has weight one
    assign prod_next[0] = nosd_pkg::OUT_WIDTH'($signed(sample.sample_value));

    // per-tap weight table over the order, one multiplier per tap
    genvar k, mm;
    generate
        for (k = 0; k < MAX_ORDER; k++)
        begin : g_tap
            logic signed [FULL_WIDTH-1:0] full;
            for (mm = 0; mm <= MAX_ORDER; mm++)
            begin : g_ord
                assign coef_tab[k][mm] =
                    nosd_pkg::COEF_WIDTH'(nosd_pkg::tap_coef(mm, k + 1));
            end
            assign full = $signed(hist[k]) * $signed(coef_tab[k][eff_order]);
            assign prod_next[k+1] = full[nosd_pkg::OUT_WIDTH-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg.vld     <= accept;
            ctrl_reg.compute <= compute;
        end
    end

    // product payload
    always_ff @(posedge clk)
    begin
        if (advance && accept)
            prod_reg <= prod_next;
    end

    assign ctrl = ctrl_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hdl/nosd_sum.sv */
`default_nettype none

module nosd_sum #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             advance,
    input  wire nosd_pkg::stage_ctrl_t                            ctrl,
    input  wire logic      [MAX_ORDER:0][nosd_pkg::OUT_WIDTH-1:0] prod,
    output logic                                                  out_valid,
    output nosd_pkg::out_t                                        out_data
);

    logic [nosd_pkg::OUT_WIDTH-1:0] acc;
    logic                           out_valid_reg;
    nosd_pkg::out_t                 out_data_reg, out_data_next;

    // add all taps, wrapping at the result width
    always_comb
    begin
        acc = '0;
        for (int i = 0; i <= MAX_ORDER; i++)
            acc = acc + prod[i];
    end

    // null and warm-up results carry a zero value
    always_comb
    begin
        out_data_next.diff_value = ctrl.compute ? $signed(acc) : '0;
        out_data_next.diff_valid = ctrl.compute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= ctrl.vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.vld)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/nth_order_stream_difference_core.sv */
// Backward difference of configurable order (1..MAX_ORDER) over a stream of
// signed Q32.16 samples, one result per request. A request is taken every
// cycle while in_ready is high; its result is registered after the per-tap
// multipliers and again after the tap adder. The block keeps accepting while
// a result waits, stalling only when both stages are full and out_ready is
// low. Null samples give a null result and leave the history alone; the
// first 'order' valid samples only fill the history. diff_order is to be
// written through cfg_we/cfg_wdata while no request is in flight, which the
// block does not enforce; 0 acts as 1, values above MAX_ORDER as MAX_ORDER.
`default_nettype none

module nth_order_stream_difference_core #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire nosd_pkg::in_t                      in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output nosd_pkg::out_t                          out_data,
    input  wire logic                               cfg_we,
    input  wire logic [nosd_pkg::ORDER_WIDTH-1:0]   cfg_wdata
);

    localparam int WW = $clog2(MAX_ORDER + 1);

    logic [MAX_ORDER-1:0][nosd_pkg::SAMPLE_WIDTH-1:0] hist;
    logic [MAX_ORDER:0][nosd_pkg::OUT_WIDTH-1:0]      prod;
    logic [WW-1:0]          eff_order;
    logic                   compute;
    logic                   accept;
    logic                   adv_out, adv_prod;
    nosd_pkg::stage_ctrl_t  prod_ctrl;

    // stage advance: a stage moves when it is empty or the next one moves
    assign adv_out  = !out_valid || out_ready;
    assign adv_prod = !prod_ctrl.vld || adv_out;
    assign in_ready = adv_prod;
    assign accept   = in_valid && in_ready;

    nosd_hist #(
        .MAX_ORDER (MAX_ORDER),
        .WW        (WW)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .sample    (in_data),
        .hist      (hist),
        .eff_order (eff_order),
        .compute   (compute)
    );

    nosd_prod #(
        .MAX_ORDER (MAX_ORDER),
        .WW        (WW)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv_prod),
        .accept    (accept),
        .sample    (in_data),
        .hist      (hist),
        .eff_order (eff_order),
        .compute   (compute),
        .ctrl      (prod_ctrl),
        .prod      (prod)
    );

    nosd_sum #(
        .MAX_ORDER (MAX_ORDER)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv_out),
        .ctrl      (prod_ctrl),
        .prod      (prod),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* hdl/nosd_checker.sv */
`default_nettype none

module nosd_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire nosd_pkg::out_t out_data
);

    logic [2:0] occ_reg, occ_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests in flight
    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
            occ_next = occ_reg + 3'd1;
        else if (out_acc && !in_acc)
            occ_next = occ_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // null results carry zero
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.diff_valid |-> out_data.diff_value == '0)
        else $error("null result with nonzero value");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // never more than two requests in flight, never a result from nothing
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'd2 && (!out_valid || occ_reg != 3'd0))
        else $error("in-flight count out of range");

endmodule

bind nth_order_stream_difference_core nosd_checker u_nosd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
